@@ hdl/windowed_power_statistics_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the windowed power statistics block
// Concurrent checks clocked on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_POWER_STATISTICS_DEFINES_SVH
`define WINDOWED_POWER_STATISTICS_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent
`define WPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent
`define WPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/wpstat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpstat_pkg
// Shared widths, reset values, register indexes and lane control type.
// ----------------------------------------------------------------------------
package wpstat_pkg;

  // Raw sample ports and the number of current inputs on the block
  localparam int IN_W                 = 12;
  localparam int INPUT_CHANNELS       = 2;

  // Defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF      = 12;
  localparam int CURRENT_CHANNELS_DEF = 2;

  // Snapshot field widths
  localparam int COUNT_W              = 16;
  localparam int SUM_W                = 28;
  localparam int SQ_W                 = 40;

  // Configuration port
  localparam int CFG_IDX_W            = 2;
  localparam int CFG_DATA_W           = 16;
  localparam int CHAN_CFG_W           = 2;

  localparam logic [COUNT_W-1:0]    WINDOW_RESET   = COUNT_W'(1000);
  localparam logic [CHAN_CFG_W-1:0] CHANNELS_RESET = CHAN_CFG_W'(1);
  localparam logic                  VOLT_EN_RESET  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH    = 2'd0,
    REG_CURRENT_CHANNELS = 2'd1,
    REG_VOLTAGE_ENABLED  = 2'd2
  } cfg_reg_t;

  // Per-lane pipeline control
  typedef struct packed {
    logic load;   // capture products of the request in the sample stage
    logic step;   // fold the product stage into the accumulators
    logic en;     // lane enabled for the request in the product stage
    logic wrap;   // window closes with this request: clear afterwards
  } lane_ctl_t;

endpackage

@@ hdl/windowed_power_statistics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_power_statistics
// Windowed sums, sums of squares and power sums of a voltage channel and
// up to two current channels, emitted as one snapshot per window.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one sample set per request:
//   a voltage sample and two current samples. The output channel
//   (out_valid/out_ready) carries one snapshot per completed window: the
//   sample count and every sum, with disabled channels reported as zero.
//   The cfg_ port writes window length, current channel count and voltage
//   enable; write it only while no request is in flight.
//   Throughput: one sample set per cycle unless a held snapshot stalls the
//   input. Each set passes a sample register, a product register (squares
//   and power products) and the accumulators. The snapshot of a window is
//   loaded from the product register as its last sample set leaves it.
//   When the receiver stalls, the pending snapshot is held; sample sets that
//   do not close a window keep flowing, and input stalls only once the next
//   closing set reaches the product register while the snapshot is still held.
//   Reset restores window length 1000, one current channel, voltage enabled,
//   and clears all accumulators and the counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "windowed_power_statistics_defines.svh"

module windowed_power_statistics #(
  parameter int SAMPLE_BITS      = wpstat_pkg::SAMPLE_BITS_DEF,
  parameter int CURRENT_CHANNELS = wpstat_pkg::CURRENT_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [wpstat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpstat_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample sets
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wpstat_pkg::IN_W-1:0]       in_voltage_sample,
  input  logic [wpstat_pkg::IN_W-1:0]       in_current_sample_a,
  input  logic [wpstat_pkg::IN_W-1:0]       in_current_sample_b,
  // snapshots
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wpstat_pkg::COUNT_W-1:0]    out_sample_count,
  output logic [wpstat_pkg::SUM_W-1:0]      out_voltage_sum,
  output logic [wpstat_pkg::SQ_W-1:0]       out_voltage_sum_sq,
  output logic [wpstat_pkg::SUM_W-1:0]      out_current_a_sum,
  output logic [wpstat_pkg::SQ_W-1:0]       out_current_a_sum_sq,
  output logic [wpstat_pkg::SQ_W-1:0]       out_current_a_power_sum,
  output logic [wpstat_pkg::SUM_W-1:0]      out_current_b_sum,
  output logic [wpstat_pkg::SQ_W-1:0]       out_current_b_sum_sq,
  output logic [wpstat_pkg::SQ_W-1:0]       out_current_b_power_sum
);

  localparam int SW    = (SAMPLE_BITS < wpstat_pkg::IN_W) ? SAMPLE_BITS : wpstat_pkg::IN_W;
  localparam int LANES = (CURRENT_CHANNELS < wpstat_pkg::INPUT_CHANNELS) ?
                         CURRENT_CHANNELS : wpstat_pkg::INPUT_CHANNELS;
  localparam int NCH   = wpstat_pkg::INPUT_CHANNELS;
  localparam int CW    = wpstat_pkg::COUNT_W;
  localparam int SUMW  = wpstat_pkg::SUM_W;
  localparam int SQW   = wpstat_pkg::SQ_W;

  // Configuration registers
  logic [CW-1:0]                       win_r;
  logic [wpstat_pkg::CHAN_CFG_W-1:0]   chan_r;
  logic                                ven_r;

  // Sample stage
  logic                s1_valid_r;
  logic [SW-1:0]       s1_v_r;
  logic [SW-1:0]       s1_c_r [LANES];
  logic [LANES-1:0]    s1_en_r;
  logic                s1_ven_r;
  logic [CW-1:0]       s1_limit_r;

  // Product stage
  logic                s2_valid_r;
  logic [SW-1:0]       s2_v_r;
  logic [2*SW-1:0]     s2_vsq_r;
  logic [LANES-1:0]    s2_en_r;
  logic                s2_ven_r;
  logic [CW-1:0]       s2_limit_r;

  // Accumulators
  logic [CW-1:0]       count_r, count_nxt;
  logic [SUMW-1:0]     vsum_r, vsum_nxt;
  logic [SQW-1:0]      vsq_r, vsq_nxt;

  // Snapshot register
  logic                out_valid_r;
  logic [CW-1:0]       out_count_r;
  logic [SUMW-1:0]     out_vsum_r;
  logic [SQW-1:0]      out_vsq_r;
  logic [SUMW-1:0]     out_sum_r [NCH];
  logic [SQW-1:0]      out_sq_r  [NCH];
  logic [SQW-1:0]      out_pw_r  [NCH];

  // Pipeline control
  logic                in_fire, s1_adv, s2_adv, s2_emit, emit_fire, out_free;
  logic [CW-1:0]       count_sum;
  logic [CW-1:0]       limit_in;
  logic [LANES-1:0]    lane_en_in;
  logic [SUMW-1:0]     vsum_snap;
  logic [SQW-1:0]      vsq_snap;
  logic [wpstat_pkg::IN_W-1:0] in_cur [NCH];
  logic [SUMW-1:0]     lane_sum [NCH];
  logic [SQW-1:0]      lane_sq  [NCH];
  logic [SQW-1:0]      lane_pw  [NCH];

  assign in_cur[0] = in_current_sample_a;
  assign in_cur[1] = in_current_sample_b;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= wpstat_pkg::WINDOW_RESET;
      chan_r <= wpstat_pkg::CHANNELS_RESET;
      ven_r  <= wpstat_pkg::VOLT_EN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wpstat_pkg::REG_WINDOW_LENGTH:    win_r  <= cfg_data[CW-1:0];
        wpstat_pkg::REG_CURRENT_CHANNELS: chan_r <= cfg_data[wpstat_pkg::CHAN_CFG_W-1:0];
        wpstat_pkg::REG_VOLTAGE_ENABLED:  ven_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Window of zero behaves as one
  assign limit_in = (win_r == '0) ? CW'(1) : win_r;

  // Handshake: only a window-closing request waits for the snapshot register
  assign count_sum = count_r + CW'(1);
  assign s2_emit   = (count_sum >= s2_limit_r);
  assign out_free  = !out_valid_r || out_ready;
  assign s2_adv    = s2_valid_r && (!s2_emit || out_free);
  assign s1_adv    = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_valid && in_ready;
  assign emit_fire = s2_adv && s2_emit;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request with the settings it runs under
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_v_r     <= ven_r ? in_voltage_sample[SW-1:0] : '0;
      s1_en_r    <= lane_en_in;
      s1_ven_r   <= ven_r;
      s1_limit_r <= limit_in;
    end
  end

  // Square the voltage sample
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_v_r     <= s1_v_r;
      s2_vsq_r   <= (2*SW)'(s1_v_r) * (2*SW)'(s1_v_r);
      s2_en_r    <= s1_en_r;
      s2_ven_r   <= s1_ven_r;
      s2_limit_r <= s1_limit_r;
    end
  end

  // Accumulate the voltage channel; a disabled channel adds zero
  assign vsum_snap = vsum_r + SUMW'(s2_v_r);
  assign vsq_snap  = vsq_r + SQW'(s2_vsq_r);

  always_comb begin
    count_nxt = count_r;
    vsum_nxt  = vsum_r;
    vsq_nxt   = vsq_r;
    if (s2_adv) begin
      if (s2_emit) begin
        count_nxt = '0;
        vsum_nxt  = '0;
        vsq_nxt   = '0;
      end else begin
        count_nxt = count_sum;
        vsum_nxt  = vsum_snap;
        vsq_nxt   = vsq_snap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      vsum_r  <= '0;
      vsq_r   <= '0;
    end else begin
      count_r <= count_nxt;
      vsum_r  <= vsum_nxt;
      vsq_r   <= vsq_nxt;
    end
  end

  // Current channel lanes; channels beyond the lane count report zero
  for (genvar i = 0; i < NCH; i++) begin : g_chan
    if (i < LANES) begin : g_lane
      wpstat_pkg::lane_ctl_t ctl;
      logic [SUMW-1:0]       snap_sum;
      logic [SQW-1:0]        snap_sq;
      logic [SQW-1:0]        snap_pw;

      assign lane_en_in[i] = (chan_r > wpstat_pkg::CHAN_CFG_W'(i));

      always_ff @(posedge clk) begin
        if (in_fire) begin
          s1_c_r[i] <= in_cur[i][SW-1:0];
        end
      end

      assign ctl.load = s1_adv;
      assign ctl.step = s2_adv;
      assign ctl.en   = s2_en_r[i];
      assign ctl.wrap = s2_emit;

      wpstat_lane #(
        .SW (SW)
      ) u_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cur_sample  (s1_c_r[i]),
        .volt_sample (s1_v_r),
        .snap_sum    (snap_sum),
        .snap_sq     (snap_sq),
        .snap_pw     (snap_pw)
      );

      assign lane_sum[i] = s2_en_r[i] ? snap_sum : '0;
      assign lane_sq[i]  = s2_en_r[i] ? snap_sq  : '0;
      assign lane_pw[i]  = (s2_en_r[i] && s2_ven_r) ? snap_pw : '0;
    end else begin : g_none
      assign lane_sum[i] = '0;
      assign lane_sq[i]  = '0;
      assign lane_pw[i]  = '0;
    end
  end

  // Load the snapshot when the window closes
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_count_r <= count_sum;
      out_vsum_r  <= s2_ven_r ? vsum_snap : '0;
      out_vsq_r   <= s2_ven_r ? vsq_snap  : '0;
      for (int k = 0; k < NCH; k++) begin
        out_sum_r[k] <= lane_sum[k];
        out_sq_r[k]  <= lane_sq[k];
        out_pw_r[k]  <= lane_pw[k];
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_sample_count        = out_count_r;
  assign out_voltage_sum         = out_vsum_r;
  assign out_voltage_sum_sq      = out_vsq_r;
  assign out_current_a_sum       = out_sum_r[0];
  assign out_current_a_sum_sq    = out_sq_r[0];
  assign out_current_a_power_sum = out_pw_r[0];
  assign out_current_b_sum       = out_sum_r[1];
  assign out_current_b_sum_sq    = out_sq_r[1];
  assign out_current_b_power_sum = out_pw_r[1];

  // Checks
  `WPS_ASSERT_SAME(a_snapshot_count_nonzero, out_valid_r, out_count_r != '0,
                   "snapshot carries a zero sample count")
  `WPS_ASSERT_NEXT(a_counter_cleared, emit_fire, count_r == '0,
                   "counter not cleared after a snapshot")
  `WPS_ASSERT_NEXT(a_counter_counts, s2_adv && !s2_emit, count_r != '0,
                   "counter empty after a request inside the window")
  `WPS_ASSERT_SAME(a_snapshot_from_close, $rose(out_valid_r), $past(emit_fire),
                   "snapshot appeared without a closing request")

endmodule

@@ hdl/wpstat_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpstat_lane
// One current channel: registered sample, square and power product, then
// the running sum, sum of squares and power sum for the window.
// ----------------------------------------------------------------------------
module wpstat_lane #(
  parameter int SW = wpstat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wpstat_pkg::lane_ctl_t        ctl,
  input  logic [SW-1:0]                cur_sample,
  input  logic [SW-1:0]                volt_sample,
  output logic [wpstat_pkg::SUM_W-1:0] snap_sum,
  output logic [wpstat_pkg::SQ_W-1:0]  snap_sq,
  output logic [wpstat_pkg::SQ_W-1:0]  snap_pw
);

  logic [SW-1:0]                c_r;
  logic [2*SW-1:0]              sq_r;
  logic [2*SW-1:0]              pw_r;
  logic [wpstat_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [wpstat_pkg::SQ_W-1:0]  sqacc_r, sqacc_nxt;
  logic [wpstat_pkg::SQ_W-1:0]  pwacc_r, pwacc_nxt;

  // Product stage: square and current times voltage
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      c_r  <= cur_sample;
      sq_r <= (2*SW)'(cur_sample) * (2*SW)'(cur_sample);
      pw_r <= (2*SW)'(cur_sample) * (2*SW)'(volt_sample);
    end
  end

  // Sums including the request in the product stage
  assign snap_sum = sum_r + wpstat_pkg::SUM_W'(c_r);
  assign snap_sq  = sqacc_r + wpstat_pkg::SQ_W'(sq_r);
  assign snap_pw  = pwacc_r + wpstat_pkg::SQ_W'(pw_r);

  // Accumulate when enabled, clear when the window closes
  always_comb begin
    sum_nxt   = sum_r;
    sqacc_nxt = sqacc_r;
    pwacc_nxt = pwacc_r;
    if (ctl.step) begin
      if (ctl.wrap) begin
        sum_nxt   = '0;
        sqacc_nxt = '0;
        pwacc_nxt = '0;
      end else if (ctl.en) begin
        sum_nxt   = snap_sum;
        sqacc_nxt = snap_sq;
        pwacc_nxt = snap_pw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      sqacc_r <= '0;
      pwacc_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      sqacc_r <= sqacc_nxt;
      pwacc_r <= pwacc_nxt;
    end
  end

endmodule
